// File: sv/nth_root_newton_core_defines.svh
// Assertion macros shared by the RTL of the n-th root core.
// Each macro places a labeled concurrent assertion clocked on the rising edge
// and disabled while the synchronous reset is asserted.
`ifndef NTH_ROOT_NEWTON_CORE_DEFINES_SVH
`define NTH_ROOT_NEWTON_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define NRN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NRN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define NRN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NRN_ASSERT(label, clk, rst_n, prop, msg)
`define NRN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define NRN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/nrn_pkg.sv
`timescale 1ns / 1ps

package nrn_pkg;

    // Width of the saturating intermediates (power and quotient).
    localparam int PW = 62;
    localparam logic [PW-1:0] WIDE_CAP = {PW{1'b1}};

    // Slice of the estimate consumed by the multiplier per pass.
    localparam int MUL_CW = 16;

    // Configuration register map.
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] CFG_TOL  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_ITER = 1'b1;

    localparam logic [15:0] TOL_RST  = 16'd66;
    localparam logic [7:0]  ITER_RST = 8'd64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BITS,
        S_EXP,
        S_MUL_P,
        S_MUL_A,
        S_QSETUP,
        S_QDIV,
        S_SCALE,
        S_SUM,
        S_NDIV,
        S_UPDATE
    } t_state;

endpackage

// File: sv/nth_root_newton_core.sv
`timescale 1ns / 1ps

// N-th root core: a request carries an unsigned 31-bit radicand and a degree;
// the core returns the degree-th root in unsigned fixed point with FRAC_BITS
// fraction bits, the number of Newton steps taken and a flag that is set when
// the iteration cap stopped the search before the tolerance was met. A request
// is taken on a rising edge with start high and busy low. Its result appears on
// the o_ result ports for exactly one cycle, marked by o_done, and must be
// captured then: the receiver has no way to stall the core. A zero radicand
// returns zero in the next cycle without raising busy. Otherwise the
// core stays busy for the whole computation, which runs on one shared
// 62x16 multiplier and one shared radix-2 restoring divider under a small
// sequencer. It first counts the bits of the radicand and forms the start
// exponent ceil(bits(a)/n), then runs Newton steps; each step makes n - 1
// multiplies by the estimate, in NCH = ceil((32 + FRAC_BITS) / 16) slices
// each, and two divider passes, which take most of the time of a step.
// The two configuration registers should only be written while busy is low.

`include "nth_root_newton_core_defines.svh"

module nth_root_newton_core
    import nrn_pkg::*;
#(
    parameter int MAX_DEGREE = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request channel.
    input  logic              start,
    output logic              busy,
    input  logic [30:0]       i_radicand,
    input  logic [4:0]        i_degree,
    // Configuration write port.
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [15:0]       i_cfg_wdata,
    // Result channel.
    output logic              o_done,
    output logic [31:0]       o_root_value,
    output logic [7:0]        o_steps_used,
    output logic              o_hit_limit
);

    // Estimate width: holds the cap 2^(31+FRAC_BITS).
    localparam int XW   = 32 + FRAC_BITS;
    // Degree register width.
    localparam int NW   = $clog2(MAX_DEGREE + 1);
    // Multiplier passes over the estimate.
    localparam int NCH  = (XW + MUL_CW - 1) / MUL_CW;
    localparam int MXW  = NCH * MUL_CW;
    localparam int CCW  = $clog2(NCH + 1);
    // Width of (n-1)*x + q.
    localparam int SW0  = (XW + NW > PW) ? XW + NW : PW;
    localparam int SW   = SW0 + 1;
    // Divider dividend width covers both a << 2F and the Newton sum.
    localparam int QIN  = 31 + 2 * FRAC_BITS;
    localparam int DVW  = (QIN > SW) ? QIN : SW;
    localparam int DCW  = $clog2(DVW + 1);
    // Accumulator for ceil(bits/n).
    localparam int EAW  = $clog2(31 + MAX_DEGREE + 1);
    localparam int ACW  = 64 + MUL_CW + 1;

    localparam logic [PW-1:0] ONE_P  = PW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] XCAP_P = PW'(1) << (31 + FRAC_BITS);

    t_state r_state, n_state;

    // Configuration registers.
    logic [15:0] r_tol;
    logic [7:0]  r_max_iter;

    // Datapath registers.
    logic [30:0]         r_a,     n_a;
    logic [30:0]         r_sh,    n_sh;
    logic [4:0]          r_bits,  n_bits;
    logic [EAW-1:0]      r_eacc,  n_eacc;
    logic [4:0]          r_e,     n_e;
    logic [NW-1:0]       r_n,     n_n;
    logic [NW-1:0]       r_k,     n_k;
    logic [XW-1:0]       r_x,     n_x;
    logic [PW-1:0]       r_p,     n_p;
    logic [MXW-1:0]      r_mx,    n_mx;
    logic [PW+MUL_CW-1:0] r_prod, n_prod;
    logic [63:0]         r_acc,   n_acc;
    logic                r_ovf,   n_ovf;
    logic [CCW-1:0]      r_ccnt,  n_ccnt;
    logic [DVW-1:0]      r_dvd,   n_dvd;
    logic [PW-1:0]       r_dsor,  n_dsor;
    logic [PW-1:0]       r_rem,   n_rem;
    logic [PW-1:0]       r_quo,   n_quo;
    logic                r_sat,   n_sat;
    logic [DCW-1:0]      r_dcnt,  n_dcnt;
    logic [PW-1:0]       r_q,     n_q;
    logic [SW-1:0]       r_sum,   n_sum;
    logic [7:0]          r_steps, n_steps;

    // Result registers.
    logic        r_done,       n_done;
    logic [31:0] r_root_value, n_root_value;
    logic [7:0]  r_steps_out,  n_steps_out;
    logic        r_hit,        n_hit;

    // Combinational helpers.
    logic [NW-1:0]       deg_eff;
    logic [7:0]          iter_cap;
    logic                start_pow;
    logic [ACW-1:0]      ma_sum;
    logic                ma_ovf;
    logic [63:0]         ma_acc;
    logic [PW-1:0]       ma_p;
    logic [PW:0]         d_rs;
    logic                d_sat;
    logic [PW-1:0]       d_qs;
    logic                d_ge;
    logic [PW-1:0]       d_rem;
    logic [PW-1:0]       d_quo;
    logic [XW+NW-1:0]    scale_prod;
    logic [SW-1:0]       nsum;
    logic [XW-1:0]       xn;
    logic [XW-1:0]       delta;
    logic [7:0]          steps_inc;

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_root_value = r_root_value;
    assign o_steps_used = r_steps_out;
    assign o_hit_limit  = r_hit;

    // A degree of zero counts as one; degrees above the supported maximum
    // are clamped to it.
    always_comb begin
        if (i_degree == 5'd0) begin
            deg_eff = NW'(1);
        end else if (int'(i_degree) > MAX_DEGREE) begin
            deg_eff = NW'(MAX_DEGREE);
        end else begin
            deg_eff = NW'(i_degree);
        end
    end

    // An iteration cap of zero behaves as a cap of one.
    assign iter_cap = (r_max_iter == 8'd0) ? 8'd1 : r_max_iter;

    // Multiplier accumulate: acc = acc * 2^16 + p * slice. The running value
    // only grows, so once it leaves 64 bits the product is known to saturate.
    assign ma_sum = {1'b0, r_acc, {MUL_CW{1'b0}}} + ACW'(r_prod);
    assign ma_ovf = r_ovf | (|ma_sum[ACW-1:64]);
    assign ma_acc = ma_sum[63:0];
    assign ma_p   = ma_ovf ? WIDE_CAP : PW'(ma_acc >> FRAC_BITS);

    // One restoring divider step. The quotient saturation mirrors the
    // behavior of a quotient register that stops shifting once it would
    // pass 62 bits.
    assign d_rs  = {r_rem, r_dvd[DVW-1]};
    assign d_sat = r_sat | r_quo[PW-1];
    assign d_qs  = d_sat ? r_quo : {r_quo[PW-2:0], 1'b0};
    assign d_ge  = (d_rs >= {1'b0, r_dsor});
    assign d_rem = d_ge ? PW'(d_rs - {1'b0, r_dsor}) : d_rs[PW-1:0];
    assign d_quo = d_qs | PW'(d_ge && !d_sat);

    // Newton update pieces.
    assign scale_prod = r_x * (r_n - NW'(1));
    assign nsum       = r_sum + SW'(r_q);
    assign xn         = (r_q > XCAP_P) ? XCAP_P[XW-1:0] : r_q[XW-1:0];
    assign delta      = (xn > r_x) ? (xn - r_x) : (r_x - xn);
    assign steps_inc  = r_steps + 8'd1;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol      <= TOL_RST;
            r_max_iter <= ITER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TOL:  r_tol      <= i_cfg_wdata;
                CFG_ITER: r_max_iter <= i_cfg_wdata[7:0];
                default:  ;
            endcase
        end
    end

    // Result strobe is control; the payload carries no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root_value <= n_root_value;
        r_steps_out  <= n_steps_out;
        r_hit        <= n_hit;
        r_a     <= n_a;
        r_sh    <= n_sh;
        r_bits  <= n_bits;
        r_eacc  <= n_eacc;
        r_e     <= n_e;
        r_n     <= n_n;
        r_k     <= n_k;
        r_x     <= n_x;
        r_p     <= n_p;
        r_mx    <= n_mx;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_ovf   <= n_ovf;
        r_ccnt  <= n_ccnt;
        r_dvd   <= n_dvd;
        r_dsor  <= n_dsor;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_sat   <= n_sat;
        r_dcnt  <= n_dcnt;
        r_q     <= n_q;
        r_sum   <= n_sum;
        r_steps <= n_steps;
    end

    // Sequencer: next state, datapath loads and the result strobe.
    always_comb begin
        n_state      = r_state;
        n_done       = 1'b0;
        n_root_value = r_root_value;
        n_steps_out  = r_steps_out;
        n_hit        = r_hit;
        n_a     = r_a;
        n_sh    = r_sh;
        n_bits  = r_bits;
        n_eacc  = r_eacc;
        n_e     = r_e;
        n_n     = r_n;
        n_k     = r_k;
        n_x     = r_x;
        n_p     = r_p;
        n_mx    = r_mx;
        n_prod  = r_prod;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_ccnt  = r_ccnt;
        n_dvd   = r_dvd;
        n_dsor  = r_dsor;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_sat   = r_sat;
        n_dcnt  = r_dcnt;
        n_q     = r_q;
        n_sum   = r_sum;
        n_steps = r_steps;
        start_pow = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_radicand == 31'd0) begin
                        // A zero radicand answers at once with no iteration.
                        n_done       = 1'b1;
                        n_root_value = 32'd0;
                        n_steps_out  = 8'd0;
                        n_hit        = 1'b0;
                    end else begin
                        n_a     = i_radicand;
                        n_sh    = i_radicand;
                        n_bits  = 5'd0;
                        n_n     = deg_eff;
                        n_steps = 8'd0;
                        n_state = S_BITS;
                    end
                end
            end

            S_BITS: begin
                // Count the significant bits of the radicand.
                if (r_sh != 31'd0) begin
                    n_sh   = r_sh >> 1;
                    n_bits = r_bits + 5'd1;
                end else begin
                    n_eacc  = '0;
                    n_e     = 5'd0;
                    n_state = S_EXP;
                end
            end

            S_EXP: begin
                // e = ceil(bits / n) by repeated addition of n.
                if (EAW'(r_bits) > r_eacc) begin
                    n_eacc = r_eacc + EAW'(r_n);
                    n_e    = r_e + 5'd1;
                end else begin
                    n_x       = XW'(1) << (int'(r_e) + FRAC_BITS);
                    start_pow = 1'b1;
                end
            end

            S_MUL_P: begin
                n_prod  = r_p * r_mx[MXW-1 -: MUL_CW];
                n_mx    = r_mx << MUL_CW;
                n_state = S_MUL_A;
            end

            S_MUL_A: begin
                n_acc  = ma_acc;
                n_ovf  = ma_ovf;
                n_ccnt = r_ccnt - CCW'(1);
                if (r_ccnt == CCW'(1)) begin
                    n_p = ma_p;
                    if (r_k == NW'(1)) begin
                        n_state = S_QSETUP;
                    end else begin
                        n_k     = r_k - NW'(1);
                        n_mx    = MXW'(r_x);
                        n_acc   = '0;
                        n_ovf   = 1'b0;
                        n_ccnt  = CCW'(NCH);
                        n_state = S_MUL_P;
                    end
                end else begin
                    n_state = S_MUL_P;
                end
            end

            S_QSETUP: begin
                // A zero power reads as a saturated quotient.
                if (r_p == '0) begin
                    n_q     = WIDE_CAP;
                    n_state = S_SCALE;
                end else begin
                    n_dvd   = DVW'(r_a) << (2 * FRAC_BITS);
                    n_dsor  = r_p;
                    n_rem   = '0;
                    n_quo   = '0;
                    n_sat   = 1'b0;
                    n_dcnt  = DCW'(DVW);
                    n_state = S_QDIV;
                end
            end

            S_QDIV: begin
                n_dvd  = r_dvd << 1;
                n_rem  = d_rem;
                n_quo  = d_quo;
                n_sat  = d_sat;
                n_dcnt = r_dcnt - DCW'(1);
                if (r_dcnt == DCW'(1)) begin
                    n_q     = d_sat ? WIDE_CAP : d_quo;
                    n_state = S_SCALE;
                end
            end

            S_SCALE: begin
                n_sum   = SW'(scale_prod);
                n_state = S_SUM;
            end

            S_SUM: begin
                // Divide (n-1)*x + q by n on the same divider.
                n_dvd   = DVW'(nsum);
                n_dsor  = PW'(r_n);
                n_rem   = '0;
                n_quo   = '0;
                n_sat   = 1'b0;
                n_dcnt  = DCW'(DVW);
                n_state = S_NDIV;
            end

            S_NDIV: begin
                n_dvd  = r_dvd << 1;
                n_rem  = d_rem;
                n_quo  = d_quo;
                n_sat  = d_sat;
                n_dcnt = r_dcnt - DCW'(1);
                if (r_dcnt == DCW'(1)) begin
                    n_q     = d_quo;
                    n_state = S_UPDATE;
                end
            end

            S_UPDATE: begin
                n_x     = xn;
                n_steps = steps_inc;
                if (delta <= XW'(r_tol) || steps_inc >= iter_cap) begin
                    n_done       = 1'b1;
                    n_root_value = (|xn[XW-1:32]) ? 32'hFFFF_FFFF : xn[31:0];
                    n_steps_out  = steps_inc;
                    n_hit        = !(delta <= XW'(r_tol));
                    n_state      = S_IDLE;
                end else begin
                    start_pow = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Begin a Newton step: p = 1.0, then n-1 multiplies by the estimate.
        if (start_pow) begin
            n_p    = ONE_P;
            n_k    = r_n - NW'(1);
            n_mx   = MXW'(n_x);
            n_acc  = '0;
            n_ovf  = 1'b0;
            n_ccnt = CCW'(NCH);
            if (r_n == NW'(1)) begin
                n_state = S_QSETUP;
            end else begin
                n_state = S_MUL_P;
            end
        end
    end

    // A result is always delivered with the sequencer back at rest.
    `NRN_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result while busy")
    // A nonzero radicand makes the core busy on the next cycle.
    `NRN_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n,
        start && !busy && (i_radicand != 31'd0), busy, "request did not start")
    // Only the zero radicand finishes with no Newton step.
    `NRN_ASSERT_IMP(a_zero_steps, i_clk, i_rst_n, o_done && (o_steps_used == 8'd0),
        (o_root_value == 32'd0) && !o_hit_limit, "zero steps with nonzero result")
    // The divider never runs with an exhausted bit counter.
    `NRN_ASSERT_IMP(a_div_count, i_clk, i_rst_n,
        (r_state == S_QDIV) || (r_state == S_NDIV), r_dcnt != '0, "divider count ran out")
    // The division by the degree can never saturate its quotient.
    `NRN_ASSERT_IMP(a_ndiv_nosat, i_clk, i_rst_n, r_state == S_NDIV, !r_sat,
        "degree division saturated")

endmodule

// File: tb/sv/nth_root_newton_core_checker.sv
`timescale 1ns / 1ps

module nth_root_newton_core_checker
    import nrn_pkg::*;
#(
    parameter int MAX_DEGREE = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [30:0]       i_radicand,
    input  logic [4:0]        i_degree,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_done,
    input  logic [31:0]       i_root_value,
    input  logic [7:0]        i_steps_used,
    input  logic              i_hit_limit,
    output int                o_pending,
    output int                o_results,
    output int                o_cap_hits,
    output int                o_fail_count
);

    localparam bit [63:0] SAT_WIDE = (64'd1 << 62) - 64'd1;
    localparam bit [63:0] X_LIMIT  = 64'd1 << (31 + FRAC_BITS);
    localparam bit [63:0] FX_ONE   = 64'd1 << FRAC_BITS;
    localparam int        LOUD_MAX = 40;

    typedef struct packed {
        logic [30:0] radicand;
        logic [4:0]  degree;
        logic [31:0] root;
        logic [7:0]  steps;
        logic        hit;
    } root_expect_t;

    root_expect_t expected_roots[$];
    logic [15:0]  tolerance;
    logic [7:0]   iter_cap_reg;
    int           fail_total   = 0;
    int           result_total = 0;
    int           cap_total    = 0;

    assign o_fail_count = fail_total;
    assign o_results    = result_total;
    assign o_cap_hits   = cap_total;

    task automatic flag_mismatch(input string msg);
        if (fail_total < LOUD_MAX) begin
            $display("[%0t] root check: %s", $time, msg);
        end
        fail_total++;
    endtask

    // Fixed-point product, truncated, saturating at the wide cap.
    function automatic bit [63:0] fixed_mul(input bit [63:0] p, input bit [63:0] x);
        bit [127:0] prod;
        if (p == 0 || x == 0) return 64'd0;
        prod = {64'd0, p} * {64'd0, x};
        if (prod[127:64] != 0) return SAT_WIDE;
        prod = prod >> FRAC_BITS;
        if (prod[63:0] > SAT_WIDE) return SAT_WIDE;
        return prod[63:0];
    endfunction

    // Bit-serial restoring division of (a << 2*FRAC_BITS) by d.
    function automatic bit [63:0] fixed_div(input bit [63:0] a, input bit [63:0] d);
        bit [63:0] rem;
        bit [63:0] quo;
        bit        sat;
        bit        b;
        rem = 0;
        quo = 0;
        sat = 1'b0;
        if (d == 0) return SAT_WIDE;
        for (int i = 31 + 2 * FRAC_BITS - 1; i >= 0; i--) begin
            b = 1'b0;
            if (i >= 2 * FRAC_BITS) b = a[i - 2 * FRAC_BITS];
            rem = (rem << 1) | {63'd0, b};
            if (!sat && quo >= (64'd1 << 61)) sat = 1'b1;
            if (!sat) quo = quo << 1;
            if (rem >= d) begin
                rem = rem - d;
                if (!sat) quo[0] = 1'b1;
            end
        end
        if (sat || quo > SAT_WIDE) return SAT_WIDE;
        return quo;
    endfunction

    function automatic root_expect_t predict_root(input logic [30:0] a, input logic [4:0] deg);
        root_expect_t r;
        bit [63:0]    n;
        bit [63:0]    cap;
        bit [63:0]    x;
        bit [63:0]    p;
        bit [63:0]    q;
        bit [63:0]    xn;
        bit [63:0]    delta;
        int           width;
        int           e;
        int           steps;
        bit           finished;
        r.radicand = a;
        r.degree   = deg;
        r.root     = '0;
        r.steps    = '0;
        r.hit      = 1'b0;
        n   = (deg == 0) ? 64'd1 : (deg > MAX_DEGREE) ? 64'(MAX_DEGREE) : 64'(deg);
        cap = (iter_cap_reg == 0) ? 64'd1 : 64'(iter_cap_reg);
        if (a == 0) return r;
        width = 0;
        while (width < 31 && (a >> width) != 0) width++;
        // Starting guess 2^ceil(bits/n) sits at or above the true root.
        e        = int'((64'(width) + n - 64'd1) / n);
        x        = 64'd1 << (e + FRAC_BITS);
        steps    = 0;
        finished = 1'b0;
        while (!finished) begin
            p = FX_ONE;
            for (int k = 1; k < n; k++) p = fixed_mul(p, x);
            q  = fixed_div({33'd0, a}, p);
            xn = ((n - 64'd1) * x + q) / n;
            if (xn > X_LIMIT) xn = X_LIMIT;
            delta = (xn > x) ? xn - x : x - xn;
            x     = xn;
            steps++;
            if (delta <= 64'(tolerance)) begin
                finished = 1'b1;
            end else if (steps >= cap) begin
                r.hit    = 1'b1;
                finished = 1'b1;
            end
        end
        r.root  = (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
        r.steps = steps[7:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        root_expect_t want;
        if (!i_rst_n) begin
            tolerance    = TOL_RST;
            iter_cap_reg = ITER_RST;
            expected_roots.delete();
        end else begin
            if (i_done) begin
                if (expected_roots.size() == 0) begin
                    flag_mismatch($sformatf("result root=%h with no request outstanding",
                                            i_root_value));
                end else begin
                    want = expected_roots.pop_front();
                    result_total++;
                    if (want.hit) cap_total++;
                    if (i_root_value !== want.root)
                        flag_mismatch($sformatf("a=%0d n=%0d root_value %h, expected %h",
                                                want.radicand, want.degree,
                                                i_root_value, want.root));
                    if (i_steps_used !== want.steps)
                        flag_mismatch($sformatf("a=%0d n=%0d steps_used %0d, expected %0d",
                                                want.radicand, want.degree,
                                                i_steps_used, want.steps));
                    if (i_hit_limit !== want.hit)
                        flag_mismatch($sformatf("a=%0d n=%0d hit_limit %b, expected %b",
                                                want.radicand, want.degree,
                                                i_hit_limit, want.hit));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_TOL) begin
                    tolerance = i_cfg_wdata;
                end else if (i_cfg_addr == CFG_ITER) begin
                    iter_cap_reg = i_cfg_wdata[7:0];
                end
            end
            if (i_start && !i_busy) begin
                expected_roots.push_back(predict_root(i_radicand, i_degree));
            end
        end
        o_pending <= expected_roots.size();
    end

endmodule

// File: tb/sv/nth_root_newton_core_test.sv
`timescale 1ns / 1ps

// Top of the n-th root regression. This module only makes stimulus and gives
// the verdict; the checker instantiated beside the core watches the request,
// result and register channels, predicts every result and counts mismatches.
module nth_root_newton_core_test;
    import nrn_pkg::*;

    localparam int          CLK_HALF       = 6;
    localparam int          RESET_CYCLES   = 12;
    // The slowest request runs 255 steps at degree 16 and outlasts the longest
    // sender gap by far. Allow several times that request.
    localparam int          WATCHDOG_LIMIT = 300000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          TAIL_CYCLES    = 400;
    localparam int          NUM_PHASES     = 8;
    localparam logic [30:0] RADICAND_MAX   = 31'h7FFF_FFFF;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              start      = 1'b0;
    logic [30:0]       radicand   = '0;
    logic [4:0]        degree     = 5'd1;
    logic              cfg_we     = 1'b0;
    logic [CFG_AW-1:0] cfg_addr   = CFG_TOL;
    logic [15:0]       cfg_wdata  = '0;
    logic              busy;
    logic              done;
    logic [31:0]       root_value;
    logic [7:0]        steps_used;
    logic              hit_limit;

    int pending;
    int results;
    int cap_hits;
    int fail_count;
    int requests       = 0;
    int settings_used  = 1;
    int quiet_cycles   = 0;

    nth_root_newton_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_radicand   (radicand),
        .i_degree     (degree),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_done       (done),
        .o_root_value (root_value),
        .o_steps_used (steps_used),
        .o_hit_limit  (hit_limit)
    );

    nth_root_newton_core_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_radicand   (radicand),
        .i_degree     (degree),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_done       (done),
        .i_root_value (root_value),
        .i_steps_used (steps_used),
        .i_hit_limit  (hit_limit),
        .o_pending    (pending),
        .o_results    (results),
        .o_cap_hits   (cap_hits),
        .o_fail_count (fail_count)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // The watchdog counts cycles in which neither a request nor a result moves.
    // A hung core or a result that never arrives ends the run here.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("nth_root_newton_core regression: fail");
            $finish;
        end
    end

    // Present one request and hold it until the core takes it. Busy is read
    // right after the edge, so it is the value the core itself sampled there.
    // Start is left high, so a back-to-back request needs no extra cycle.
    task automatic send_request(input logic [30:0] a, input logic [4:0] n);
        start    <= 1'b1;
        radicand <= a;
        degree   <= n;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        requests++;
    endtask

    // Drop start for a while. The payload ports carry junk meanwhile, which the
    // core has to ignore.
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            start    <= 1'b0;
            radicand <= 31'($urandom);
            degree   <= 5'($urandom);
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every outstanding request has produced its
    // result and the core is idle. The first edge lets the checker's pending
    // count catch up with a request taken at the current edge.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back. The cap register only keeps the low
    // byte, so the upper byte of its write data gets random junk.
    task automatic write_setting(input logic [15:0] tol, input logic [7:0] cap);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_TOL;
        cfg_wdata <= tol;
        @(posedge i_clk);
        cfg_addr  <= CFG_ITER;
        cfg_wdata <= {8'($urandom), cap};
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cfg_wdata <= 16'($urandom);
        settings_used++;
    endtask

    // Most gaps are short or absent. A few are long enough that the core sits
    // idle for a while between requests.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8) return 0;
        if (r < 17) return $urandom_range(1, 4);
        if (r < 19) return $urandom_range(5, 40);
        return $urandom_range(100, 400);
    endfunction

    // Radicands are a mix: zero, tiny values, random bit widths, values near the
    // top of the range, powers of two, perfect squares and full-width values.
    function automatic logic [30:0] pick_radicand();
        int          r;
        int unsigned k;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return 31'($urandom_range(1, 255));
        if (r <= 4) return 31'($urandom) >> $urandom_range(0, 30);
        if (r == 5) return RADICAND_MAX - 31'($urandom_range(0, 3));
        if (r == 6) return 31'd1 << $urandom_range(0, 30);
        if (r == 7) begin
            k = $urandom_range(1, 46340);
            return 31'(k * k);
        end
        return 31'($urandom);
    endfunction

    // Degrees favor the cheap low orders but reach the whole legal range, with
    // some zero degrees and some above the maximum, which the core clamps.
    function automatic logic [4:0] pick_degree();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 5'($urandom_range(17, 31));
        if (r == 1) return 5'd0;
        if (r < 8) return 5'($urandom_range(1, 4));
        return 5'($urandom_range(1, 16));
    endfunction

    // Register settings per phase, with the number of random requests in each.
    // Phase 0 runs on the reset values. Zero tolerance with the largest cap is
    // the slowest case, so that phase stays short.
    task automatic phase_setting(input int ph, output logic [15:0] tol, output logic [7:0] cap,
                                 output int count);
        case (ph)
            0: begin tol = TOL_RST;   cap = ITER_RST; count = 100; end
            1: begin tol = 16'd0;     cap = 8'd255;   count = 20;  end
            2: begin tol = 16'hFFFF;  cap = 8'd1;     count = 80;  end
            3: begin tol = 16'd0;     cap = 8'd0;     count = 50;  end
            4: begin tol = 16'd1000;  cap = 8'd8;     count = 100; end
            5: begin tol = 16'd1;     cap = 8'd3;     count = 80;  end
            6: begin tol = 16'd250;   cap = 8'd128;   count = 60;  end
            default: begin tol = TOL_RST; cap = ITER_RST; count = 40; end
        endcase
    endtask

    initial begin
        logic [15:0] tol;
        logic [7:0]  cap;
        int          count;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests on the reset settings: zero radicands, degree one
        // with roots too wide for the output, the largest radicand at several
        // degrees, a zero degree, degrees above the maximum, exact powers and
        // alternating bit patterns.
        send_request(31'd0, 5'd1);
        send_request(31'd0, 5'd16);
        send_request(31'd1, 5'd1);
        send_request(31'd65535, 5'd1);
        send_request(31'd65536, 5'd1);
        send_request(RADICAND_MAX, 5'd1);
        send_request(31'd1, 5'd16);
        send_request(RADICAND_MAX, 5'd16);
        send_request(31'd2, 5'd2);
        send_request(31'd4, 5'd2);
        send_request(RADICAND_MAX, 5'd2);
        send_request(31'd1000000, 5'd3);
        send_request(31'd27, 5'd3);
        send_request(31'd100, 5'd0);
        send_request(RADICAND_MAX, 5'd17);
        send_request(31'd1, 5'd31);
        send_request(31'd12345, 5'd30);
        send_request(31'h4000_0000, 5'd15);
        send_request(31'h5555_5555, 5'd7);
        send_request(31'h2AAA_AAAA, 5'd10);
        send_request(31'd3, 5'd16);
        send_request(31'h7FFF_FFFE, 5'd5);
        send_request(31'd1024, 5'd10);
        send_request(31'd5, 5'd4);

        // Random phases. Each new setting is written only once the core has
        // drained, so the sender sees a full pause at every phase boundary.
        // Within a phase, the first part of every stretch of forty requests
        // goes back to back and the rest uses random gaps.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            phase_setting(ph, tol, cap, count);
            if (ph != 0) begin
                wait_for_results();
                write_setting(tol, cap);
            end
            for (int i = 0; i < count; i++) begin
                if ((i % 40) >= 12) pause_sender(sender_gap());
                send_request(pick_radicand(), pick_degree());
            end
        end

        // Let every result come back, then watch a little longer for strays.
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests under %0d register settings", requests, settings_used);
        $display("%0d results compared, %0d of them stopped by the iteration cap",
                 results, cap_hits);
        if (fail_count == 0) begin
            $display("nth_root_newton_core regression: pass");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("nth_root_newton_core regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/nrn_pkg.sv
sv/nth_root_newton_core.sv
tb/sv/nth_root_newton_core_checker.sv
tb/sv/nth_root_newton_core_test.sv
